[rtl/afb_pkg.sv]
// ----------------------------------------------------------------------------
// afb_pkg: shared types and constants of the attribute frame buffer
// Request and register codes, store reset values, default store depths and
// the command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package afb_pkg;

  // Default store depths in bytes.
  localparam int PIXEL_DEPTH_DEF = 8192;
  localparam int ATTR_DEPTH_DEF  = 8192;

  // Width of a computed store address, and of the limit compare.
  // The largest address is 255 * 63 + 31, which fits 14 bits.
  localparam int CALC_W = 14;
  localparam int LIM_W  = 17;

  // Request codes.
  localparam logic [1:0] REQ_PLOT = 2'd0;
  localparam logic [1:0] REQ_PICK = 2'd1;
  localparam logic [1:0] REQ_READ = 2'd2;
  localparam logic [1:0] REQ_LOAD = 2'd3;

  // Pen slots.
  localparam logic [1:0] PEN_INK    = 2'd0;
  localparam logic [1:0] PEN_PAPER  = 2'd1;
  localparam logic [1:0] PEN_BRIGHT = 2'd2;
  localparam logic [1:0] PEN_FLASH  = 2'd3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_TALL   = 2'd2;

  // Reset and special values.
  localparam logic [7:0] DEFAULT_ATTR    = 8'h47;
  localparam logic [7:0] DEFAULT_PIXELS  = 8'h00;
  localparam logic [3:0] TRANSPARENT_PEN = 4'd8;
  localparam logic [3:0] INK_PEN_RESET   = 4'd7;
  localparam logic [8:0] WIDTH_RESET     = 9'd256;
  localparam logic [8:0] HEIGHT_RESET    = 9'd192;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;    // write reset values at the sweep counter
    logic capture;  // take a request and start the store reads
    logic finish;   // write back, update pens and load the result
  } afb_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;   // sweep counter at the last entry
    logic out_blocked;  // result register full and stalled
  } afb_sts_t;

endpackage

[rtl/afb_ram.sv]
// ----------------------------------------------------------------------------
// afb_ram: generic single-port RAM
// One access per cycle, write or read, with registered read data.
// ----------------------------------------------------------------------------
module afb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // A write leaves the read register untouched.
  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

[rtl/afb_ctrl.sv]
// ----------------------------------------------------------------------------
// afb_ctrl: request sequencer
// Runs the clearing sweep after reset, then takes one request at a time:
// a capture cycle for the store reads and a finish cycle for the write back.
// ----------------------------------------------------------------------------
module afb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  afb_pkg::afb_sts_t sts,
  output afb_pkg::afb_cmd_t cmd
);

  import afb_pkg::*;

  typedef enum logic [2:0] {
    S_CLEAR = 3'b001,
    S_IDLE  = 3'b010,
    S_RUN   = 3'b100
  } state_t;

  state_t state_r, state_nxt;

  // Next state and commands.
  always_comb begin
    state_nxt   = state_r;
    cmd.clear   = 1'b0;
    cmd.capture = 1'b0;
    cmd.finish  = 1'b0;
    unique case (state_r)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = S_RUN;
        end
      end
      S_RUN: begin
        if (!sts.out_blocked) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);

endmodule

[rtl/afb_datapath.sv]
// ----------------------------------------------------------------------------
// afb_datapath: stores, pens, configuration and result register
// Computes store addresses and the range test, reads both stores, merges
// the pens into the cell attribute and holds the finished result.
// ----------------------------------------------------------------------------
module afb_datapath #(
  parameter int PIXEL_DEPTH = afb_pkg::PIXEL_DEPTH_DEF,
  parameter int ATTR_DEPTH  = afb_pkg::ATTR_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  afb_pkg::afb_cmd_t cmd,
  output afb_pkg::afb_sts_t sts,
  // Configuration writes
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [8:0]        cfg_data,
  // Request fields
  input  logic [1:0]        in_req_type,
  input  logic [7:0]        in_x_pos,
  input  logic [7:0]        in_y_pos,
  input  logic              in_pixel_on,
  input  logic [1:0]        in_pen_slot,
  input  logic [3:0]        in_pen_value,
  // Result
  output logic              out_valid,
  input  logic              out_stall,
  output logic              out_status,
  output logic [7:0]        out_pixel_byte,
  output logic [3:0]        out_ink_colour,
  output logic [3:0]        out_paper_colour,
  output logic              out_flash_on,
  output logic [3:0]        out_picked_value
);

  import afb_pkg::*;

  localparam int PAW  = $clog2(PIXEL_DEPTH);
  localparam int AAW  = $clog2(ATTR_DEPTH);
  localparam int MAXD = (PIXEL_DEPTH > ATTR_DEPTH) ? PIXEL_DEPTH : ATTR_DEPTH;
  localparam int CW   = $clog2(MAXD);

  // Configuration registers.
  logic [8:0] width_r;
  logic [8:0] height_r;
  logic       tall_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= WIDTH_RESET;
      height_r <= HEIGHT_RESET;
      tall_r   <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_WIDTH:  width_r  <= cfg_data;
        CFG_HEIGHT: height_r <= cfg_data;
        CFG_TALL:   tall_r   <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // Address and range test on the incoming request.
  logic [5:0]        stride;
  logic [7:0]        cell_row;
  logic [CALC_W-1:0] pix_calc;
  logic [CALC_W-1:0] att_calc;
  logic              in_range_calc;

  always_comb begin
    stride   = width_r[8:3];
    cell_row = tall_r ? {3'b000, in_y_pos[7:3]} : in_y_pos;
    pix_calc = CALC_W'(in_y_pos) * CALC_W'(stride) + CALC_W'(in_x_pos[7:3]);
    att_calc = CALC_W'(cell_row) * CALC_W'(stride) + CALC_W'(in_x_pos[7:3]);
    in_range_calc = ({1'b0, in_x_pos} < {width_r[8:3], 3'b000})
                  && ({1'b0, in_y_pos} < height_r)
                  && (LIM_W'(pix_calc) < LIM_W'(PIXEL_DEPTH))
                  && (LIM_W'(att_calc) < LIM_W'(ATTR_DEPTH));
  end

  // Captured request.
  logic [1:0]     req_r;
  logic [2:0]     bit_r;
  logic           on_r;
  logic [1:0]     slot_r;
  logic [3:0]     val_r;
  logic           in_range_r;
  logic [PAW-1:0] pix_addr_r;
  logic [AAW-1:0] att_addr_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r      <= in_req_type;
      bit_r      <= in_x_pos[2:0];
      on_r       <= in_pixel_on;
      slot_r     <= in_pen_slot;
      val_r      <= in_pen_value;
      in_range_r <= in_range_calc;
      pix_addr_r <= PAW'(pix_calc);
      att_addr_r <= AAW'(att_calc);
    end
  end

  // Clearing sweep counter.
  logic [CW-1:0] clr_cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_cnt_r <= '0;
    end else if (cmd.clear) begin
      clr_cnt_r <= clr_cnt_r + 1'b1;
    end
  end

  assign sts.clear_last = (clr_cnt_r == CW'(MAXD - 1));

  // Store access decisions.
  logic           plot_wr;
  logic           pix_en, pix_we, att_en, att_we;
  logic [PAW-1:0] pix_addr;
  logic [AAW-1:0] att_addr;
  logic [7:0]     pix_wdata, att_wdata, pix_rdata, att_rdata;
  logic [7:0]     pix_new, att_new;

  assign plot_wr = cmd.finish && in_range_r && (req_r == REQ_PLOT);

  always_comb begin
    pix_en    = cmd.capture || plot_wr;
    pix_we    = plot_wr;
    pix_addr  = cmd.capture ? PAW'(pix_calc) : pix_addr_r;
    pix_wdata = pix_new;
    att_en    = cmd.capture || plot_wr;
    att_we    = plot_wr;
    att_addr  = cmd.capture ? AAW'(att_calc) : att_addr_r;
    att_wdata = att_new;
    if (cmd.clear) begin
      pix_en    = ({1'b0, clr_cnt_r} < (CW + 1)'(PIXEL_DEPTH));
      pix_we    = 1'b1;
      pix_addr  = PAW'(clr_cnt_r);
      pix_wdata = DEFAULT_PIXELS;
      att_en    = ({1'b0, clr_cnt_r} < (CW + 1)'(ATTR_DEPTH));
      att_we    = 1'b1;
      att_addr  = AAW'(clr_cnt_r);
      att_wdata = DEFAULT_ATTR;
    end
  end

  afb_ram #(.WIDTH(8), .DEPTH(PIXEL_DEPTH)) u_pix_ram (
    .clk   (clk),
    .en    (pix_en),
    .we    (pix_we),
    .addr  (pix_addr),
    .wdata (pix_wdata),
    .rdata (pix_rdata)
  );

  afb_ram #(.WIDTH(8), .DEPTH(ATTR_DEPTH)) u_att_ram (
    .clk   (clk),
    .en    (att_en),
    .we    (att_we),
    .addr  (att_addr),
    .wdata (att_wdata),
    .rdata (att_rdata)
  );

  // Pens.
  logic [3:0] pen_r [4];

  // A transparent pen keeps the old field; any other is cut to the field.
  function automatic logic [2:0] merge3(input logic [3:0] pen, input logic [2:0] old);
    merge3 = (pen == TRANSPARENT_PEN) ? old : pen[2:0];
  endfunction

  function automatic logic merge1(input logic [3:0] pen, input logic old);
    merge1 = (pen == TRANSPARENT_PEN) ? old : pen[0];
  endfunction

  // Pixel and attribute merge for a plot, and the cell colours.
  logic [7:0] pix_mask;
  logic [3:0] ink_full, paper_full, picked;

  always_comb begin
    pix_mask   = 8'h80 >> bit_r;
    pix_new    = on_r ? (pix_rdata | pix_mask) : (pix_rdata & ~pix_mask);
    att_new    = {merge1(pen_r[PEN_FLASH], att_rdata[7]),
                  merge1(pen_r[PEN_BRIGHT], att_rdata[6]),
                  merge3(pen_r[PEN_PAPER], att_rdata[5:3]),
                  merge3(pen_r[PEN_INK], att_rdata[2:0])};
    ink_full   = {att_rdata[6], att_rdata[2:0]};
    paper_full = {att_rdata[6], att_rdata[5:3]};
    picked     = (slot_r == PEN_INK) ? ink_full : paper_full;
  end

  // Pen updates on load, and on pick when in range.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pen_r[PEN_INK]    <= INK_PEN_RESET;
      pen_r[PEN_PAPER]  <= '0;
      pen_r[PEN_BRIGHT] <= '0;
      pen_r[PEN_FLASH]  <= '0;
    end else if (cmd.finish) begin
      if (req_r == REQ_LOAD) begin
        pen_r[slot_r] <= val_r;
      end else if (req_r == REQ_PICK && in_range_r) begin
        pen_r[slot_r] <= picked;
      end
    end
  end

  // Result register; a new result may enter as the old one is taken.
  logic       out_valid_r;
  logic       status_r;
  logic [7:0] pixel_byte_r;
  logic [3:0] ink_colour_r, paper_colour_r, picked_value_r;
  logic       flash_on_r;
  logic       is_read, is_pick;

  assign is_read = (req_r == REQ_READ) && in_range_r;
  assign is_pick = (req_r == REQ_PICK) && in_range_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.finish) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      status_r       <= (req_r != REQ_LOAD) && !in_range_r;
      pixel_byte_r   <= is_read ? pix_rdata : 8'h00;
      ink_colour_r   <= is_read ? ink_full : 4'h0;
      paper_colour_r <= is_read ? paper_full : 4'h0;
      flash_on_r     <= is_read && att_rdata[7];
      picked_value_r <= is_pick ? picked : 4'h0;
    end
  end

  assign sts.out_blocked = out_valid_r && out_stall;

  assign out_valid        = out_valid_r;
  assign out_status       = status_r;
  assign out_pixel_byte   = pixel_byte_r;
  assign out_ink_colour   = ink_colour_r;
  assign out_paper_colour = paper_colour_r;
  assign out_flash_on     = flash_on_r;
  assign out_picked_value = picked_value_r;

endmodule

[rtl/attribute_framebuffer.sv]
// A request is captured when accepted and its result is registered by the
// finish command, which waits while a held result is stalled. No request is
// taken until the last is finished, as the single-port stores read in the
// capture cycle and write back in the finish cycle. Reset: a clearing sweep
// over both stores fills them with their reset values; in_stall stays high
// until it ends, while configuration writes are taken throughout.
// ----------------------------------------------------------------------------
// attribute_framebuffer: 1-bit pixel store with a colour attribute store
// Plots, picks and reads pixels and cell colours and loads the four pens.
// ----------------------------------------------------------------------------
module attribute_framebuffer #(
  parameter int PIXEL_DEPTH = afb_pkg::PIXEL_DEPTH_DEF,
  parameter int ATTR_DEPTH  = afb_pkg::ATTR_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  // Configuration port
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_data,
  // Request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_req_type,
  input  logic [7:0] in_x_pos,
  input  logic [7:0] in_y_pos,
  input  logic       in_pixel_on,
  input  logic [1:0] in_pen_slot,
  input  logic [3:0] in_pen_value,
  // Result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_status,
  output logic [7:0] out_pixel_byte,
  output logic [3:0] out_ink_colour,
  output logic [3:0] out_paper_colour,
  output logic       out_flash_on,
  output logic [3:0] out_picked_value
);

  import afb_pkg::*;

  afb_cmd_t cmd;
  afb_sts_t sts;

  // Registers are always open for a transfer.
  assign cfg_ready = 1'b1;

  afb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  afb_datapath #(
    .PIXEL_DEPTH (PIXEL_DEPTH),
    .ATTR_DEPTH  (ATTR_DEPTH)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .cfg_we           (cfg_valid && cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_req_type      (in_req_type),
    .in_x_pos         (in_x_pos),
    .in_y_pos         (in_y_pos),
    .in_pixel_on      (in_pixel_on),
    .in_pen_slot      (in_pen_slot),
    .in_pen_value     (in_pen_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_pixel_byte   (out_pixel_byte),
    .out_ink_colour   (out_ink_colour),
    .out_paper_colour (out_paper_colour),
    .out_flash_on     (out_flash_on),
    .out_picked_value (out_picked_value)
  );

endmodule
